### rtl/avsq_pkg.sv
// Package for the frame timestamp queue: sizes, action codes, payload types
// and the command bundle between controller and datapath. No dependencies.
package avsq_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUEUE_LIMIT = 2'd0,
        REG_KEEP_LAST   = 2'd1,
        REG_SYNC_WINDOW = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ACT_EMPTY   = 3'd0,
        ACT_DISPLAY = 3'd1,
        ACT_SKIP    = 3'd2,
        ACT_HOLD    = 3'd3,
        ACT_PUSHED  = 3'd4,
        ACT_FULL    = 3'd5
    } t_action;

    localparam logic MODE_PUSH    = 1'b0;
    localparam logic MODE_REFRESH = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] frame_time;
        logic signed [31:0] audio_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] shown_time;
        logic [CNT_W-1:0]   fill_level;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

### rtl/av_sync_frame_queue.sv
// Top level of the frame timestamp queue: controller plus datapath.
// Depends on avsq_pkg, avsq_ctrl and avsq_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one transaction
//   per push (mode 0, frame_time) or refresh tick (mode 1, audio_time).
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//   transaction per input: action, examined frame time and fill level.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 queue limit, 1 keep-last, 2 sync window) at once; write only when idle.
// Sequencing: the input and its timestamp memory read are registered at
//   acceptance; the compare and queue update then load the result register
//   once it is free. One item is in progress at a time: no new input is
//   accepted until the compare and queue update of the last one are done.
// Reset: indexes, fill count and shown mark clear; registers return to
//   limit 12, keep-last on, window 40 ms. Stored timestamps are not cleared.
// Stall: the result register holds while i_out_ready is low; one more input
//   is accepted and waits in the datapath until the result register frees.
module av_sync_frame_queue
    import avsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;

    avsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    avsq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.fill_level <= CNT_W'(SLOTS)))
        else $error("fill level above queue size");

    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.action == ACT_EMPTY)
            |-> (o_out_data.fill_level == '0 && o_out_data.shown_time == '0))
        else $error("empty result with nonzero level or time");

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction accepted while one is in progress");
`endif

endmodule

### rtl/avsq_ctrl.sv
// Controller for the frame timestamp queue: transaction handshakes and
// sequencing of the datapath. Depends on avsq_pkg.
module avsq_ctrl
    import avsq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd.capture = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.execute = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (o_cmd.execute) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (o_cmd.execute) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/avsq_dp.sv
// Datapath for the frame timestamp queue: timestamp memory, ring indexes,
// configuration registers, lag compare and the result register. Depends on avsq_pkg.
module avsq_dp
    import avsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_item             o_out_data
);

    logic [31:0]           r_mem [SLOTS];
    logic [31:0]           r_rd_data;
    logic                  r_mode;
    logic signed [31:0]    r_frame;
    logic signed [31:0]    r_audio;
    logic [IDX_W-1:0]      r_read_slot;
    logic [IDX_W-1:0]      r_write_slot;
    logic [CNT_W-1:0]      r_count;
    logic                  r_shown;
    logic [CNT_W-1:0]      r_limit;
    logic                  r_keep;
    logic [CFG_DATA_W-1:0] r_window;
    t_out_item             r_out;

    logic [IDX_W-1:0]      n_read_slot;
    logic [IDX_W-1:0]      n_write_slot;
    logic [CNT_W-1:0]      n_count;
    logic                  n_shown;
    logic                  mem_we;
    t_out_item             n_out;
    logic [IDX_W:0]        eff_limit;
    logic signed [32:0]    diff;
    logic signed [32:0]    win;

    function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] idx,
                                              input logic [IDX_W:0] lim);
        logic [IDX_W:0] nxt;
        nxt = {1'b0, idx} + 1'b1;
        return (nxt >= lim) ? '0 : nxt[IDX_W-1:0];
    endfunction

    always_comb begin
        if (r_limit == '0) begin
            eff_limit = (IDX_W+1)'(1);
        end else if ({{(IDX_W+1){1'b0}}, r_limit} > SLOTS) begin
            eff_limit = (IDX_W+1)'(SLOTS);
        end else begin
            eff_limit = (IDX_W+1)'(r_limit);
        end
    end

    assign diff = {r_rd_data[31], r_rd_data} - {r_audio[31], r_audio};
    assign win  = {{(33-CFG_DATA_W){1'b0}}, r_window};

    always_comb begin
        n_read_slot  = r_read_slot;
        n_write_slot = r_write_slot;
        n_count      = r_count;
        n_shown      = r_shown;
        mem_we       = 1'b0;
        n_out.action     = ACT_EMPTY;
        n_out.shown_time = '0;
        if (r_mode == MODE_PUSH) begin
            if ({{(IDX_W+1){1'b0}}, r_count} >= {{CNT_W{1'b0}}, eff_limit}) begin
                n_out.action = ACT_FULL;
            end else begin
                mem_we       = 1'b1;
                n_write_slot = bump(r_write_slot, eff_limit);
                n_count      = r_count + 1'b1;
                n_out.action = ACT_PUSHED;
            end
        end else if (r_count != '0) begin
            n_out.shown_time = r_rd_data;
            if (diff > win) begin
                n_out.action = ACT_HOLD;
            end else begin
                n_out.action = (diff <= -win) ? ACT_SKIP : ACT_DISPLAY;
                if (r_keep && !r_shown) begin
                    n_shown = 1'b1;
                end else begin
                    n_read_slot = bump(r_read_slot, eff_limit);
                    n_count     = r_count - 1'b1;
                end
            end
        end
        n_out.fill_level = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && mem_we) begin
            r_mem[r_write_slot] <= r_frame;
        end
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[r_read_slot];
            r_mode    <= i_in_data.mode;
            r_frame   <= i_in_data.frame_time;
            r_audio   <= i_in_data.audio_time;
        end
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_slot  <= '0;
            r_write_slot <= '0;
            r_count      <= '0;
            r_shown      <= 1'b0;
            r_limit      <= CNT_W'(12);
            r_keep       <= 1'b1;
            r_window     <= CFG_DATA_W'(40);
        end else begin
            if (i_cmd.execute) begin
                r_read_slot  <= n_read_slot;
                r_write_slot <= n_write_slot;
                r_count      <= n_count;
                r_shown      <= n_shown;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_QUEUE_LIMIT: r_limit  <= i_cfg_data[CNT_W-1:0];
                    REG_KEEP_LAST:   r_keep   <= i_cfg_data[0];
                    REG_SYNC_WINDOW: r_window <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_out_data = r_out;

endmodule

### verif/tb.sv
// Self-checking testbench for av_sync_frame_queue: pushes and refresh ticks,
// with results checked against a behavioral model of the timestamp queue.
// Depends on avsq_pkg and the av_sync_frame_queue RTL.
module tb;
    import avsq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [SLOTS-1:0][31:0] times;
        logic [SLOTS-1:0]       written;
        logic [IDX_W-1:0]       rd;
        logic [IDX_W-1:0]       wr;
        logic [CNT_W-1:0]       cnt;
        logic                   shown;
        logic [4:0]             limit;
        logic                   keep;
        logic [9:0]             window;
    } t_sync_queue;

    logic                  i_clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_in_item    frame_requests[$];
    t_out_item   expected_actions[$];
    t_sync_queue live_queue;
    t_sync_queue plan_queue;
    t_out_item   oldest;
    int          errors = 0;
    int          cycles = 0;
    int          idle_pct = 24;
    int          media_ms = 0;
    int          hold_left = 0;
    bit          hold_armed = 1'b0;
    bit          hold_done = 1'b0;

    av_sync_frame_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] idx, int lim);
        return (int'(idx) + 1 >= lim) ? '0 : idx + 1'b1;
    endfunction

    function automatic t_out_item sync_queue_step(inout t_sync_queue q, input t_in_item it);
        t_out_item         r;
        int                lim;
        longint            lag;
        longint            win;
        logic signed [31:0] t;
        logic              adv;
        r = '0;
        adv = 1'b0;
        lim = (q.limit == 0) ? 1 : (q.limit > SLOTS) ? SLOTS : int'(q.limit);
        win = q.window;
        if (it.mode == MODE_PUSH) begin
            if (q.cnt >= lim) begin
                r.action = ACT_FULL;
            end else begin
                q.times[q.wr] = it.frame_time;
                q.written[q.wr] = 1'b1;
                q.wr = next_slot(q.wr, lim);
                q.cnt = q.cnt + 1'b1;
                r.action = ACT_PUSHED;
            end
        end else if (q.cnt == 0) begin
            r.action = ACT_EMPTY;
        end else begin
            t = q.times[q.rd];
            lag = longint'(t) - longint'($signed(it.audio_time));
            r.shown_time = t;
            if (lag <= -win) begin
                r.action = ACT_SKIP;
                adv = 1'b1;
            end else if (lag <= win) begin
                r.action = ACT_DISPLAY;
                adv = 1'b1;
            end else begin
                r.action = ACT_HOLD;
            end
        end
        if (adv) begin
            if (q.keep && !q.shown) begin
                q.shown = 1'b1;
            end else begin
                q.rd = next_slot(q.rd, lim);
                if (q.cnt > 0) q.cnt = q.cnt - 1'b1;
            end
        end
        r.fill_level = q.cnt;
        return r;
    endfunction

    function automatic void apply_reg(inout t_sync_queue q, input t_cfg_reg r,
                                      input logic [CFG_DATA_W-1:0] v);
        case (r)
            REG_QUEUE_LIMIT: q.limit = v[4:0];
            REG_KEEP_LAST:   q.keep = v[0];
            REG_SYNC_WINDOW: q.window = v;
            default: ;
        endcase
    endfunction

    // never refresh onto a slot that holds no written timestamp
    function automatic void queue_request(logic mode, logic [31:0] ft, logic [31:0] at);
        t_in_item  it;
        t_out_item discard;
        it.mode = mode;
        it.frame_time = ft;
        it.audio_time = at;
        if (mode == MODE_REFRESH && plan_queue.cnt != 0 && !plan_queue.written[plan_queue.rd])
            it.mode = MODE_PUSH;
        discard = sync_queue_step(plan_queue, it);
        frame_requests.push_back(it);
    endfunction

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void queue_random(int push_pct);
        logic [31:0] ft;
        logic [31:0] at;
        int          head;
        int          span;
        head = plan_queue.times[plan_queue.rd];
        span = int'(plan_queue.window) + 4;
        media_ms += $urandom_range(40, 1);
        case ($urandom_range(9))
            0: ft = $urandom;
            1: ft = extreme_value();
            default: ft = media_ms + $urandom_range(20) - 10;
        endcase
        case ($urandom_range(9))
            0: at = $urandom;
            1: at = extreme_value();
            default: at = head + $urandom_range(2 * span) - span;
        endcase
        queue_request(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_REFRESH, ft, at);
    endfunction

    task automatic write_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= r;
        cfg_data <= v;
        apply_reg(live_queue, r, v);
        apply_reg(plan_queue, r, v);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (frame_requests.size() > 0 || in_valid || expected_actions.size() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                expected_actions.push_back(sync_queue_step(live_queue, in_data));
            if (!in_valid || in_ready) begin
                if (frame_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= frame_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_actions.size() == 0) begin
                    $display("%0t: unexpected transaction: expected none, actual %p",
                             $time, out_data);
                    errors++;
                end else begin
                    oldest = expected_actions.pop_front();
                    check_field("action", oldest.action, out_data.action);
                    check_field("shown_time", oldest.shown_time, out_data.shown_time);
                    check_field("fill_level", oldest.fill_level, out_data.fill_level);
                end
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_armed && !hold_done) begin
                out_ready <= 1'b0;
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial begin
        plan_queue = '0;
        plan_queue.limit = 5'd12;
        plan_queue.keep = 1'b1;
        plan_queue.window = 10'd40;
        live_queue = plan_queue;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        queue_request(MODE_REFRESH, 32'd0, 32'd0);
        queue_request(MODE_PUSH, 32'd100, 32'd0);
        queue_request(MODE_PUSH, 32'h8000_0000, 32'd0);
        queue_request(MODE_PUSH, 32'h7FFF_FFFF, 32'd0);
        queue_request(MODE_PUSH, -32'sd5, 32'd0);
        queue_request(MODE_REFRESH, 32'd0, 32'd100);
        queue_request(MODE_REFRESH, 32'd0, 32'd100);
        queue_request(MODE_REFRESH, 32'd0, 32'd0);
        queue_request(MODE_REFRESH, 32'd0, 32'h8000_0000);
        queue_request(MODE_REFRESH, 32'd0, 32'h7FFF_FFFF);
        queue_request(MODE_REFRESH, 32'd0, 32'd35);
        queue_request(MODE_PUSH, 32'd1000, 32'd0);
        queue_request(MODE_REFRESH, 32'd0, 32'd960);
        queue_request(MODE_PUSH, 32'd1000, 32'd0);
        queue_request(MODE_REFRESH, 32'd0, 32'd959);
        queue_request(MODE_REFRESH, 32'd0, 32'd961);
        settle();

        write_reg(REG_QUEUE_LIMIT, 10'd16);
        write_reg(REG_KEEP_LAST, 10'd0);
        write_reg(REG_SYNC_WINDOW, 10'd0);
        repeat (100) queue_random(50);
        settle();

        write_reg(REG_QUEUE_LIMIT, 10'd1);
        write_reg(REG_KEEP_LAST, 10'd1);
        write_reg(REG_SYNC_WINDOW, 10'd1023);
        repeat (60) queue_random(50);
        settle();

        write_reg(REG_QUEUE_LIMIT, 10'd31);
        write_reg(REG_KEEP_LAST, 10'd0);
        write_reg(REG_SYNC_WINDOW, 10'd1000);
        hold_armed = 1'b1;
        repeat (80) queue_random(70);
        settle();

        write_reg(REG_QUEUE_LIMIT, 10'd0);
        write_reg(REG_SYNC_WINDOW, 10'd17);
        repeat (40) queue_random(50);
        settle();

        write_reg(REG_QUEUE_LIMIT, 10'd16);
        repeat (20) queue_random(90);
        settle();

        write_reg(REG_QUEUE_LIMIT, 10'd3);
        write_reg(REG_SYNC_WINDOW, 10'd500);
        repeat (80) queue_random(40);
        settle();

        write_reg(REG_QUEUE_LIMIT, 10'd7);
        write_reg(REG_SYNC_WINDOW, 10'd63);
        idle_pct = 0;
        repeat (100) queue_random(50);
        settle();
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
rtl/avsq_pkg.sv
rtl/avsq_ctrl.sv
rtl/avsq_dp.sv
rtl/av_sync_frame_queue.sv
verif/tb.sv
